[hw/rtl/ffa_pkg.sv]
// Package for the first-fit free-list allocator.
// Holds the field widths, operation and status codes, and the header word types.
// No dependencies.
`default_nettype none

package ffa_pkg;

   localparam int IDX_W      = 12;             // unit index width
   localparam int UNITS_W    = 13;             // arena size register width
   localparam int BYTES_W    = 16;             // request size width
   localparam int NEED_W     = BYTES_W + 1;    // units needed, header included
   localparam int UNIT_SPACE = 1 << IDX_W;     // units reachable by an index
   localparam int MIN_UNITS  = 2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOM = 1'b1;

   // One block header: link to the next free block and block length in units.
   typedef struct packed {
      logic [IDX_W-1:0] link;
      logic [IDX_W-1:0] len;
   } hdr_word_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      hdr_word_type     data;
   } hdr_wr_type;

endpackage

`default_nettype wire

[hw/rtl/ffa_if.sv]
// Channel interfaces of the allocator: request, response and configuration.
// Depends on ffa_pkg for the field widths.
`default_nettype none

interface ffa_req_if import ffa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [BYTES_W-1:0] request_bytes;
   logic [IDX_W-1:0]   block_unit;

   modport source (output valid, output mode, output request_bytes, output block_unit,
                   input ready);
   modport sink   (input valid, input mode, input request_bytes, input block_unit,
                   output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             status;
   logic [IDX_W-1:0] alloc_unit;

   modport source (output valid, output status, output alloc_unit, input ready);
   modport sink   (input valid, input status, input alloc_unit, output ready);
endinterface

interface ffa_csr_if import ffa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [UNITS_W-1:0] arena_units;

   modport source (output valid, output arena_units, input ready);
   modport sink   (input valid, input arena_units, output ready);
endinterface

`default_nettype wire

[hw/rtl/first_fit_free_list_allocator.sv]
// First-fit free-list allocator, searching next-fit from a roving pointer: alloc turns the
// byte count into units, walks the free list and unlinks or splits a block; free walks to
// the insertion point and merges; one request at a time, taken only in the idle state.
// Reset and every arena_units write start a clearing pass over the min(ARENA_UNITS, 4096)
// words of the header store, during which no request is taken.
// Depends on ffa_pkg, ffa_if, ffa_header_ram and ffa_unit_calc.
`default_nettype none

module first_fit_free_list_allocator import ffa_pkg::*; #(
   parameter int ARENA_UNITS = 4096,
   parameter int UNIT_BYTES  = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   ffa_req_if.sink   req_chan,
   ffa_rsp_if.source rsp_chan,
   ffa_csr_if.sink   csr_chan
);

   // Only the first 4096 units can be named by a 12-bit index, so the store
   // never needs to be deeper than that.
   localparam int DEPTH = (ARENA_UNITS < UNIT_SPACE) ? ARENA_UNITS : UNIT_SPACE;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_A_NEED  = 4'd2;
   localparam logic [3:0] ST_A_FIRST = 4'd3;
   localparam logic [3:0] ST_A_WALK  = 4'd4;
   localparam logic [3:0] ST_A_SPLIT = 4'd5;
   localparam logic [3:0] ST_F_WALK  = 4'd6;
   localparam logic [3:0] ST_F_RD_FP = 4'd7;
   localparam logic [3:0] ST_F_RD_NX = 4'd8;
   localparam logic [3:0] ST_F_WR_P  = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [UNITS_W-1:0] units_ff, units_in;
   logic [IDX_W-1:0]   rover_ff, rover_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]   fp_ff, fp_in;
   logic [IDX_W-1:0]   p_ff, p_in;
   logic [IDX_W-1:0]   prev_idx_ff, prev_idx_in;
   logic [IDX_W-1:0]   nx_ff, nx_in;
   logic [NEED_W-1:0]  need_ff, need_in;
   logic [UNITS_W-1:0] steps_ff, steps_in;
   hdr_word_type       prev_word_ff, prev_word_in;
   hdr_word_type       fp_word_ff, fp_word_in;
   logic               res_status_ff, res_status_in;
   logic [IDX_W-1:0]   res_unit_ff, res_unit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]   rsp_unit_ff, rsp_unit_in;

   hdr_wr_type         wr;
   logic [IDX_W-1:0]   rd_idx;
   hdr_word_type       rdw;

   logic               req_xfer;
   logic               csr_xfer;
   logic               out_free;
   logic               calc_start;
   logic               calc_valid;
   logic [NEED_W-1:0]  calc_need;

   // Scratch values of the walk and merge steps.
   logic [IDX_W-1:0]   rest;
   logic [IDX_W-1:0]   nx;
   logic               brk;
   logic               fp_in_range;
   hdr_word_type       fp_new;
   logic [UNITS_W-1:0] csr_val;

   ffa_header_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_idx  (rd_idx),
      .rd_word (rdw)
   );

   ffa_unit_calc #(.UNIT_BYTES(UNIT_BYTES)) u_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (calc_start),
      .bytes     (req_chan.request_bytes),
      .out_valid (calc_valid),
      .need      (calc_need)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_xfer       = csr_chan.valid && csr_chan.ready;

   // The response register takes a new result once its current one has
   // been transferred or in the cycle that transfer happens.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.alloc_unit = rsp_unit_ff;

   always_comb begin
      state_in      = state_ff;
      units_in      = units_ff;
      rover_in      = rover_ff;
      clr_idx_in    = clr_idx_ff;
      fp_in         = fp_ff;
      p_in          = p_ff;
      prev_idx_in   = prev_idx_ff;
      nx_in         = nx_ff;
      need_in       = need_ff;
      steps_in      = steps_ff;
      prev_word_in  = prev_word_ff;
      fp_word_in    = fp_word_ff;
      res_status_in = res_status_ff;
      res_unit_in   = res_unit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_unit_in   = rsp_unit_ff;

      wr          = '0;
      rd_idx      = p_ff;
      calc_start  = 1'b0;

      rest        = rdw.len - need_ff[IDX_W-1:0];
      nx          = rdw.link;
      brk         = ((p_ff < fp_ff) && (fp_ff < nx))
                 || ((p_ff >= nx) && ((fp_ff > p_ff) || (fp_ff < nx)));
      fp_in_range = (UNITS_W'(fp_ff) < UNITS_W'(DEPTH));
      fp_new      = '0;
      csr_val     = csr_chan.arena_units;

      case (state_ff)
         ST_CLEAR: begin
            // Every header goes to zero except the sentinel and the one free
            // block that spans the rest of the arena.
            wr.en  = 1'b1;
            wr.idx = clr_idx_ff;
            if (clr_idx_ff == IDX_W'(0)) begin
               wr.data = hdr_word_type'{link: IDX_W'(1), len: '0};
            end else if (clr_idx_ff == IDX_W'(1)) begin
               wr.data = hdr_word_type'{link: '0, len: IDX_W'(units_ff - UNITS_W'(1))};
            end
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_xfer) begin
               steps_in = '0;
               if (req_chan.mode == MODE_FREE) begin
                  fp_in         = req_chan.block_unit - IDX_W'(1);
                  p_in          = rover_ff;
                  rd_idx        = rover_ff;
                  res_status_in = STATUS_OK;
                  res_unit_in   = '0;
                  state_in      = ST_F_WALK;
               end else begin
                  calc_start = 1'b1;
                  state_in   = ST_A_NEED;
               end
            end
         end

         ST_A_NEED: begin
            if (calc_valid) begin
               need_in  = calc_need;
               rd_idx   = rover_ff;
               state_in = ST_A_FIRST;
            end
         end

         ST_A_FIRST: begin
            // The search starts at the block after the rover.
            prev_idx_in  = rover_ff;
            prev_word_in = rdw;
            p_in         = rdw.link;
            rd_idx       = rdw.link;
            state_in     = ST_A_WALK;
         end

         ST_A_WALK: begin
            if (NEED_W'(rdw.len) == need_ff) begin
               // Exact fit: unlink the block from its predecessor.
               wr.en         = 1'b1;
               wr.idx        = prev_idx_ff;
               wr.data       = hdr_word_type'{link: rdw.link, len: prev_word_ff.len};
               rover_in      = prev_idx_ff;
               res_status_in = STATUS_OK;
               res_unit_in   = p_ff + IDX_W'(1);
               state_in      = ST_DONE;
            end else if (NEED_W'(rdw.len) > need_ff) begin
               // Larger block: shrink it and carve the request from its tail.
               // The tail header is read now so its link survives the rewrite.
               wr.en    = 1'b1;
               wr.idx   = p_ff;
               wr.data  = hdr_word_type'{link: rdw.link, len: rest};
               p_in     = p_ff + rest;
               rd_idx   = p_ff + rest;
               state_in = ST_A_SPLIT;
            end else if (p_ff == rover_ff || steps_ff > units_ff) begin
               // Back at the start, or the list is corrupt: out of memory.
               res_status_in = STATUS_OOM;
               res_unit_in   = '0;
               state_in      = ST_DONE;
            end else begin
               steps_in     = steps_ff + UNITS_W'(1);
               prev_idx_in  = p_ff;
               prev_word_in = rdw;
               p_in         = rdw.link;
               rd_idx       = rdw.link;
            end
         end

         ST_A_SPLIT: begin
            wr.en         = 1'b1;
            wr.idx        = p_ff;
            wr.data       = hdr_word_type'{link: rdw.link, len: need_ff[IDX_W-1:0]};
            rover_in      = prev_idx_ff;
            res_status_in = STATUS_OK;
            res_unit_in   = p_ff + IDX_W'(1);
            state_in      = ST_DONE;
         end

         ST_F_WALK: begin
            // Find the free block after which the freed block belongs in
            // address order; the wrap-around block covers both list ends.
            if (brk) begin
               prev_word_in = rdw;
               nx_in        = nx;
               rd_idx       = fp_ff;
               state_in     = ST_F_RD_FP;
            end else if (steps_ff > units_ff) begin
               state_in = ST_DONE;
            end else begin
               steps_in = steps_ff + UNITS_W'(1);
               p_in     = nx;
               rd_idx   = nx;
            end
         end

         ST_F_RD_FP: begin
            fp_word_in = rdw;
            rd_idx     = nx_ff;
            state_in   = ST_F_RD_NX;
         end

         ST_F_RD_NX: begin
            // Merge with the upper neighbor when the freed block ends at it.
            if (UNITS_W'(fp_ff) + UNITS_W'(fp_word_ff.len) == UNITS_W'(nx_ff)) begin
               fp_new = hdr_word_type'{link: rdw.link, len: fp_word_ff.len + rdw.len};
            end else begin
               fp_new = hdr_word_type'{link: nx_ff, len: fp_word_ff.len};
            end
            wr.en      = 1'b1;
            wr.idx     = fp_ff;
            wr.data    = fp_new;
            fp_word_in = fp_in_range ? fp_new : '0;
            state_in   = ST_F_WR_P;
         end

         ST_F_WR_P: begin
            // Merge with the lower neighbor when it ends at the freed block.
            wr.en  = 1'b1;
            wr.idx = p_ff;
            if (UNITS_W'(p_ff) + UNITS_W'(prev_word_ff.len) == UNITS_W'(fp_ff)) begin
               wr.data = hdr_word_type'{link: fp_word_ff.link,
                                        len: prev_word_ff.len + fp_word_ff.len};
            end else begin
               wr.data = hdr_word_type'{link: fp_ff, len: prev_word_ff.len};
            end
            rover_in = p_ff;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_unit_in   = res_unit_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            clr_idx_in = '0;
            state_in   = ST_CLEAR;
         end
      endcase

      // A write of arena_units clamps the value and rebuilds the free list.
      if (csr_xfer) begin
         if (csr_val < UNITS_W'(MIN_UNITS)) begin
            units_in = UNITS_W'(MIN_UNITS);
         end else if (csr_val > UNITS_W'(DEPTH)) begin
            units_in = UNITS_W'(DEPTH);
         end else begin
            units_in = csr_val;
         end
         clr_idx_in = '0;
         rover_in   = IDX_W'(1);
         state_in   = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         units_ff     <= UNITS_W'(DEPTH);
         rover_ff     <= IDX_W'(1);
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         units_ff     <= units_in;
         rover_ff     <= rover_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fp_ff         <= fp_in;
      p_ff          <= p_in;
      prev_idx_ff   <= prev_idx_in;
      nx_ff         <= nx_in;
      need_ff       <= need_in;
      steps_ff      <= steps_in;
      prev_word_ff  <= prev_word_in;
      fp_word_ff    <= fp_word_in;
      res_status_ff <= res_status_in;
      res_unit_ff   <= res_unit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_unit_ff   <= rsp_unit_in;
   end

endmodule

`default_nettype wire

[hw/rtl/ffa_header_ram.sv]
// Header store: one write port, one read port with registered read data.
// Depends on ffa_pkg. Indices at or beyond DEPTH read as zero and drop writes.
`default_nettype none

module ffa_header_ram import ffa_pkg::*; #(
   parameter int DEPTH = 4096
) (
   input  wire logic         clock,
   input  wire hdr_wr_type   wr,
   input  wire logic [IDX_W-1:0] rd_idx,
   output hdr_word_type      rd_word
);

   localparam int AW = $clog2(DEPTH);

   hdr_word_type hdr_mem [DEPTH];
   hdr_word_type rd_word_ff;
   logic         rd_ok_ff;
   logic         rd_ok;
   logic         wr_ok;

   assign rd_ok = (UNITS_W'(rd_idx) < UNITS_W'(DEPTH));
   assign wr_ok = (UNITS_W'(wr.idx) < UNITS_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (wr.en && wr_ok) begin
         hdr_mem[wr.idx[AW-1:0]] <= wr.data;
      end
      rd_word_ff <= hdr_mem[rd_idx[AW-1:0]];
      rd_ok_ff   <= rd_ok;
   end

   assign rd_word = rd_ok_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

[hw/rtl/ffa_unit_calc.sv]
// Converts a byte request into whole units plus one header unit.
// Depends on ffa_pkg. Three stages: reciprocal multiply, remainder, correction.
`default_nettype none

module ffa_unit_calc import ffa_pkg::*; #(
   parameter int UNIT_BYTES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [BYTES_W-1:0] bytes,
   output logic                    out_valid,
   output logic [NEED_W-1:0]       need
);

   localparam int XW    = BYTES_W + 1;
   localparam int SHIFT = XW + 1;
   localparam int RECIP = (1 << SHIFT) / UNIT_BYTES;
   localparam int RW    = $clog2(RECIP + 1);
   localparam int PW    = XW + RW;
   localparam int QW    = PW - SHIFT;

   logic [2:0]        vld_ff, vld_in;
   logic [XW-1:0]     x_ff, x_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [QW-1:0]     q0_ff, q0_in;
   logic [XW-1:0]     rem_ff, rem_in;
   logic [NEED_W-1:0] need_ff, need_in;

   // The truncated reciprocal gives the quotient or one less; the remainder
   // then stays below twice the unit size and one compare corrects it.
   always_comb begin
      vld_in  = {vld_ff[1:0], in_valid};
      x_in    = XW'(bytes) + XW'(UNIT_BYTES - 1);
      prod_in = PW'(x_in) * PW'(RECIP);
      q0_in   = prod_ff[PW-1:SHIFT];
      rem_in  = x_ff - XW'(q0_in * UNIT_BYTES);
      need_in = NEED_W'(q0_ff) + NEED_W'(1)
              + ((rem_ff >= XW'(UNIT_BYTES)) ? NEED_W'(1) : NEED_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
      q0_ff   <= q0_in;
      rem_ff  <= rem_in;
      need_ff <= need_in;
   end

   assign out_valid = vld_ff[2];
   assign need      = need_ff;

endmodule

`default_nettype wire

[hw/rtl/ffa_checker.sv]
// Port-level checks of the allocator, attached to the top level by bind.
// Depends on ffa_pkg and first_fit_free_list_allocator.
`default_nettype none

module ffa_checker import ffa_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic             rsp_status,
   input wire logic [IDX_W-1:0] rsp_alloc_unit,
   input wire logic             csr_valid,
   input wire logic             csr_ready
);

   logic [1:0] pend_ff, pend_in;

   // Requests taken whose response has not yet been transferred.
   always_comb begin
      pend_in = pend_ff + ((req_valid && req_ready) ? 2'd1 : 2'd0)
                        - ((rsp_valid && rsp_ready) ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_alloc_unit))
      else $error("response changed while stalled");

   a_rebuild_blocks_req: assert property (@(posedge clock)
      reset || (csr_valid && csr_ready) |=> !req_ready)
      else $error("request taken during free list rebuild");

   a_oom_zero_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OOM |-> rsp_alloc_unit == '0)
      else $error("out of memory response carries a unit");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests pending");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_alloc_unit (rsp_chan.alloc_unit),
   .csr_valid      (csr_chan.valid),
   .csr_ready      (csr_chan.ready)
);

`default_nettype wire

[sim/first_fit_free_list_allocator_tb.sv]
// Self-checking testbench for the first-fit free-list allocator.
// Depends on ffa_pkg, the channel interfaces in ffa_if and the allocator RTL.
`default_nettype none

module first_fit_free_list_allocator_tb;
   import ffa_pkg::*;

   localparam int ARENA_UNITS = 4096;
   localparam int UNIT_BYTES  = 16;
   localparam int CLK_PERIOD  = 10;
   localparam int ARENA_REG   = 0;     // index of the arena size register
   localparam int LIVE_CAP    = 48;    // most blocks held at once in steady traffic
   localparam int TAIL_CYCLES = 64;    // settling time after the last response

   // One response as the allocator reports it.
   typedef struct packed {
      logic             status;
      logic [IDX_W-1:0] unit;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset;

   ffa_req_if req_bus ();
   ffa_rsp_if rsp_bus ();
   ffa_csr_if csr_bus ();

   first_fit_free_list_allocator #(
      .ARENA_UNITS (ARENA_UNITS),
      .UNIT_BYTES  (UNIT_BYTES)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the allocator state. Every header word of the arena is
   // mirrored here together with the roving pointer and the arena size.
   // ---------------------------------------------------------------------
   hdr_word_type     shadow_hdr [UNIT_SPACE];
   logic [IDX_W-1:0] shadow_rover;
   int unsigned      shadow_units;

   alloc_rsp_type    pending_rsp [$];   // responses still owed by the allocator
   logic [IDX_W-1:0] live_blocks [$];   // data units currently handed out
   int               error_count = 0;
   bit               idle_on     = 1'b1;

   function automatic void put_hdr(input int unsigned idx, input int unsigned link,
                                   input int unsigned len);
      shadow_hdr[idx % UNIT_SPACE] = '{link: IDX_W'(link), len: IDX_W'(len)};
   endfunction

   // The register value is cut to its 13 bits and then held between two
   // units and the size of the header store.
   function automatic int unsigned clamp_arena(input logic [UNITS_W-1:0] value);
      int unsigned units;
      int unsigned top;
      units = value;
      top   = (ARENA_UNITS < UNIT_SPACE) ? ARENA_UNITS : UNIT_SPACE;
      if (units < MIN_UNITS) units = MIN_UNITS;
      if (units > top) units = top;
      return units;
   endfunction

   // A rebuild wipes the store and leaves the sentinel at unit 0 pointing
   // at one free block that spans the rest of the arena.
   function automatic void rebuild_arena();
      foreach (shadow_hdr[i]) shadow_hdr[i] = '0;
      put_hdr(0, 1, 0);
      put_hdr(1, 0, shadow_units - 1);
      shadow_rover = 1;
   endfunction

   function automatic void arena_write(input int reg_idx, input logic [UNITS_W-1:0] value);
      if (reg_idx != ARENA_REG) return;
      shadow_units = clamp_arena(value);
      rebuild_arena();
   endfunction

   // Next-fit search from the block after the rover. An exact fit is
   // unlinked; a larger block keeps its head and gives up its tail.
   function automatic void shadow_alloc(input logic [BYTES_W-1:0] bytes, output logic ok,
                                        output logic [IDX_W-1:0] unit);
      int unsigned need;
      int unsigned prev;
      int unsigned p;
      int unsigned steps;
      int unsigned rest;
      need  = (int'(bytes) + UNIT_BYTES - 1) / UNIT_BYTES + 1;
      prev  = shadow_rover;
      p     = shadow_hdr[prev].link;
      steps = 0;
      ok    = 1'b0;
      unit  = '0;
      while (shadow_hdr[p].len < need) begin
         if (p == shadow_rover) return;
         steps++;
         // A corrupt list never closes; give up without touching the state.
         if (steps > shadow_units + 1) return;
         prev = p;
         p    = shadow_hdr[p].link;
      end
      if (shadow_hdr[p].len == need) begin
         put_hdr(prev, shadow_hdr[p].link, shadow_hdr[prev].len);
      end else begin
         rest = shadow_hdr[p].len - need;
         put_hdr(p, shadow_hdr[p].link, rest);
         p = (p + rest) % UNIT_SPACE;
         put_hdr(p, shadow_hdr[p].link, need);
      end
      shadow_rover = prev;
      unit = IDX_W'(p + 1);
      ok   = 1'b1;
   endfunction

   // Address-ordered insertion with merging on both sides. The address is
   // taken on trust, so any unit may be handed in.
   function automatic void shadow_free(input logic [IDX_W-1:0] data_unit);
      int unsigned fp;
      int unsigned p;
      int unsigned nx;
      int unsigned steps;
      fp    = (int'(data_unit) + UNIT_SPACE - 1) % UNIT_SPACE;
      p     = shadow_rover;
      steps = 0;
      while (1'b1) begin
         nx = shadow_hdr[p].link;
         if (p < fp && fp < nx) break;
         if (p >= nx && (fp > p || fp < nx)) break;
         steps++;
         if (steps > shadow_units + 1) return;
         p = nx;
      end
      nx = shadow_hdr[p].link;
      // The adjacency tests use the full sums, not sums cut to index width.
      if (fp + shadow_hdr[fp].len == nx)
         put_hdr(fp, shadow_hdr[nx].link, shadow_hdr[fp].len + shadow_hdr[nx].len);
      else
         put_hdr(fp, nx, shadow_hdr[fp].len);
      if (p + shadow_hdr[p].len == fp)
         put_hdr(p, shadow_hdr[fp].link, shadow_hdr[p].len + shadow_hdr[fp].len);
      else
         put_hdr(p, fp, shadow_hdr[p].len);
      shadow_rover = p;
   endfunction

   function automatic alloc_rsp_type predict_request(input logic mode,
                                                     input logic [BYTES_W-1:0] bytes,
                                                     input logic [IDX_W-1:0] unit);
      alloc_rsp_type    rsp;
      logic             ok;
      logic [IDX_W-1:0] got;
      rsp = '{status: STATUS_OK, unit: '0};
      if (mode == MODE_ALLOC) begin
         shadow_alloc(bytes, ok, got);
         if (ok) rsp.unit = got;
         else    rsp.status = STATUS_OOM;
      end else begin
         shadow_free(unit);
      end
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // Checking. Every response transfer is matched against the oldest
   // expectation, and every mismatch prints one line and is counted.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   always @(posedge clock) begin
      alloc_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_bus.status, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.alloc_unit !== want.unit)
               report_mismatch("alloc_unit", rsp_bus.alloc_unit, want.unit);
         end
      end
   end

   // The response side stalls in random bursts while idling is enabled and
   // otherwise keeps ready high in stretches of random length.
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Request driving. Valid is left high after a transfer so that back to
   // back requests do not drop it; every caller either sends again at the
   // next falling edge or lowers it through drain_requests.
   // ---------------------------------------------------------------------
   task automatic send_req(input logic mode, input logic [BYTES_W-1:0] bytes,
                           input logic [IDX_W-1:0] unit, output logic [IDX_W-1:0] got);
      int            gap;
      alloc_rsp_type want;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= mode;
      req_bus.request_bytes <= bytes;
      req_bus.block_unit    <= unit;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      want = predict_request(mode, bytes, unit);
      pending_rsp.push_back(want);
      got = want.unit;
      if (mode == MODE_ALLOC && want.status == STATUS_OK) live_blocks.push_back(want.unit);
   endtask

   // The field that the operation ignores is filled with random bits.
   task automatic alloc_req(input logic [BYTES_W-1:0] bytes, output logic [IDX_W-1:0] got);
      send_req(MODE_ALLOC, bytes, IDX_W'($urandom()), got);
   endtask

   task automatic free_req(input logic [IDX_W-1:0] unit);
      logic [IDX_W-1:0] unused;
      send_req(MODE_FREE, BYTES_W'($urandom()), unit, unused);
   endtask

   // Lowers the request valid and waits until every response has arrived.
   // Each request yields exactly one response, so the allocator is idle then.
   task automatic drain_requests();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Writes the arena size once the allocator is idle. The write starts a
   // clearing pass; requests sent afterwards simply wait for ready.
   task automatic write_arena(input logic [UNITS_W-1:0] value);
      drain_requests();
      @(negedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.arena_units <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      arena_write(ARENA_REG, value);
      live_blocks.delete();
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Directed work on the arena left by reset: splits from the tail, an
   // exact refit of a hole, merges below, above and on both sides, a request
   // for the whole arena, requests too large to fit, and a free of unit 0,
   // which names the header at the top of the index space.
   task automatic test_reset_layout();
      logic [IDX_W-1:0] blk_a, blk_b, blk_c, hdr_only, one_byte, whole, unused;
      alloc_req(16'd16, blk_a);
      alloc_req(16'd32, blk_b);
      alloc_req(16'd16, blk_c);
      free_req(blk_b);
      alloc_req(16'd17, blk_b);
      alloc_req(16'd0, hdr_only);
      alloc_req(16'd1, one_byte);
      free_req(blk_a);
      free_req(blk_c);
      free_req(blk_b);
      free_req(one_byte);
      free_req(hdr_only);
      alloc_req(16'd65504, whole);
      alloc_req(16'd0, unused);
      alloc_req(16'hFFFF, unused);
      free_req(whole);
      free_req('0);
   endtask

   // Register extremes: values below the minimum and above the store size
   // are clamped, and the smallest arena holds a single header-only block.
   task automatic test_arena_register();
      logic [IDX_W-1:0] blk, unused;
      write_arena('0);
      alloc_req(16'd0, blk);
      alloc_req(16'd0, unused);
      free_req(blk);
      alloc_req(16'd16, unused);
      write_arena(13'd1);
      write_arena(13'h1FFF);
      alloc_req(16'd65504, unused);
      write_arena(13'd4097);
      write_arena(13'd3);
      repeat (3) alloc_req(16'd0, unused);
   endtask

   // Well-formed traffic: allocations of random size and frees of blocks
   // that are actually held, in random order. Now and then a request takes a random
   // 16-bit size, often far too large, which walks the whole list and comes back out of memory.
   task automatic test_steady_traffic(input int unsigned arena, input int count);
      int unsigned      max_bytes;
      int               pick;
      logic [IDX_W-1:0] unused;
      write_arena(UNITS_W'(arena));
      max_bytes = arena * UNIT_BYTES / 6;
      if (max_bytes > 16'hFFFF) max_bytes = 16'hFFFF;
      repeat (count) begin
         if (live_blocks.size() == 0 ||
             (live_blocks.size() < LIVE_CAP && $urandom_range(0, 99) < 55)) begin
            if ($urandom_range(0, 15) == 0)
               alloc_req(BYTES_W'($urandom()), unused);
            else
               alloc_req(BYTES_W'($urandom_range(0, max_bytes)), unused);
         end else begin
            pick = $urandom_range(0, live_blocks.size() - 1);
            free_req(live_blocks[pick]);
            live_blocks.delete(pick);
         end
      end
   endtask

   // Noise on a small arena: frees of arbitrary units, including ones that
   // were never handed out, break the list, and later walks must stop at
   // their step limit. The small arena keeps those walks short.
   task automatic test_unchecked_frees(input int unsigned arena, input int count);
      logic [IDX_W-1:0] unit;
      logic [IDX_W-1:0] unused;
      write_arena(UNITS_W'(arena));
      repeat (count) begin
         if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 1) == 0)
               unit = IDX_W'($urandom());
            else
               unit = IDX_W'($urandom_range(0, arena + 1));
            free_req(unit);
         end else if ($urandom_range(0, 1) == 0) begin
            alloc_req(BYTES_W'($urandom_range(0, arena * UNIT_BYTES)), unused);
         end else begin
            alloc_req(BYTES_W'($urandom()), unused);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence.
   // ---------------------------------------------------------------------
   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_ALLOC;
      req_bus.request_bytes = '0;
      req_bus.block_unit    = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.arena_units   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      shadow_units = clamp_arena(13'd4096);
      rebuild_arena();

      test_reset_layout();
      test_arena_register();
      test_steady_traffic(4096, 450);
      test_steady_traffic(200, 300);
      test_unchecked_frees(24, 150);
      test_steady_traffic(37, 250);
      test_unchecked_frees(9, 100);
      test_steady_traffic(1000, 300);
      // The last stretch runs with both sides at full rate.
      idle_on = 1'b0;
      test_steady_traffic(4096, 150);

      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("first_fit_free_list_allocator_tb: PASS");
      else
         $display("first_fit_free_list_allocator_tb: FAIL");
      $finish;
   end

   // Watchdog, sized for every request walking a list that never closes.
   initial begin
      #400000000;
      $display("first_fit_free_list_allocator_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_if.sv
hw/rtl/ffa_header_ram.sv
hw/rtl/ffa_unit_calc.sv
hw/rtl/first_fit_free_list_allocator.sv
hw/rtl/ffa_checker.sv
sim/first_fit_free_list_allocator_tb.sv
